// ===== rtl/core/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3_pkg: shared types, constants and functions for the SM3 hash engine
// Payload structs for both channels, the initial vector, the round constants
// and the rotate and permutation helpers used by the round and expansion logic.
// ----------------------------------------------------------------------------
package sm3_pkg;

    // Input transaction: up to four big-endian message bytes
    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } msg_t;

    // Output transaction: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } digest_t;

    // Byte view of a 32-bit word, byte 3 is the first (most significant) byte
    typedef logic [3:0][7:0] word_bytes_t;

    localparam int unsigned ChainWords = 8;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds     = 64;

    localparam logic [31:0] IV [ChainWords] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [31:0] T_LOW     = 32'h79CC4519;
    localparam logic [31:0] T_HIGH    = 32'h7A879D8A;
    localparam logic [7:0]  PAD_MARK  = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;
    localparam logic [2:0]  WORD_BYTES = 3'd4;

    // Rotate left; a shift by 32 yields zero, so a rotate by 0 returns x
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [5:0] rn;
        rn = 6'd32 - {1'b0, n};
        return (x << n) | (x >> rn);
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    // Round constant rotated by the round index modulo 32, computed per round
    function automatic logic [31:0] t_rot(input logic [5:0] j);
        logic [31:0] t;
        t = (j[5:4] == 2'd0) ? T_LOW : T_HIGH;
        return rotl32(t, j[4:0]);
    endfunction

endpackage

// ===== rtl/core/sm3_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sm3_hash_engine: SM3 hash over a stream of big-endian 32-bit words
// Packs message bytes into a 16-word block, compresses each full block with
// one shared round unit, pads on the last word and returns the 256-bit digest
// as eight words.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload          handshake
//  --------  ---------  ---------------  ---------------------------
//  msg       in         sm3_pkg::msg_t    msg_valid / msg_ready
//  digest    out        sm3_pkg::digest_t digest_valid / digest_ready
//
//  A word-aligned four-byte word is written into the block as a whole; other
//  words are written one valid byte at a time. Each full block runs 64 rounds
//  through the single round unit and one fold into the chaining value, after
//  which absorbing resumes. A last word adds padding of 9 to 72 bytes, written
//  at one byte per cycle except while a block is compressed or the engine moves
//  on to the length bytes, and then eight digest transactions.
//  msg_ready is high only while the engine is idle.
//  Reset loads the initial vector and clears the byte counters; the digest
//  register holds its word while digest_ready is low.
//
module sm3_hash_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_ready,
    input  sm3_pkg::msg_t     msg,
    output logic              digest_valid,
    input  logic              digest_ready,
    output sm3_pkg::digest_t  digest
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RET_ABSORB,
        RET_ZERO,
        RET_OUT
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    logic [5:0]  fill_reg, fill_next;
    logic [60:0] bytes_reg, bytes_next;
    logic [5:0]  rnd_reg, rnd_next;
    // Byte index of the input word, length byte index, or digest word index
    logic [2:0]  step_reg, step_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    sm3_pkg::digest_t out_data_reg, out_data_next;

    logic [31:0] chain_reg [sm3_pkg::ChainWords];
    logic [31:0] chain_next [sm3_pkg::ChainWords];

    // Datapath payload, no reset
    sm3_pkg::word_bytes_t win_reg [sm3_pkg::BlockWords];
    sm3_pkg::word_bytes_t win_next [sm3_pkg::BlockWords];
    logic [31:0] work_reg [sm3_pkg::ChainWords];
    logic [31:0] work_next [sm3_pkg::ChainWords];
    sm3_pkg::word_bytes_t word_reg, word_next;

    // Block write request
    logic        put_byte_en;
    logic        put_word_en;
    logic [7:0]  put_byte;

    // Round unit
    logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, w_new;
    logic [2:0]  sat_cnt;
    logic [63:0] len_bits;
    logic [7:0][7:0] len_bytes;
    logic        wrap_byte, wrap_word;

    assign sat_cnt   = (msg.valid_bytes > sm3_pkg::WORD_BYTES) ? sm3_pkg::WORD_BYTES
                                                                : msg.valid_bytes;
    assign len_bits  = {bytes_reg, 3'b000};
    assign len_bytes = len_bits;
    assign wrap_byte = (fill_reg == 6'd63);
    assign wrap_word = (fill_reg == 6'd60);

    // Compute one SM3 round and one expanded word from the window
    always_comb
    begin
        a12 = sm3_pkg::rotl32(work_reg[0], 5'd12);
        ss1 = sm3_pkg::rotl32(a12 + work_reg[4] + sm3_pkg::t_rot(rnd_reg), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg[5:4] == 2'd0)
        begin
            ffv = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            ggv = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ffv = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
                | (work_reg[1] & work_reg[2]);
            ggv = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ffv + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = ggv + work_reg[7] + ss1 + win_reg[0];
        w_new = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl32(win_reg[13], 5'd15))
              ^ sm3_pkg::rotl32(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // Sequence absorb, padding, rounds and digest output
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        bytes_next     = bytes_reg;
        rnd_next       = rnd_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        word_next      = word_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        win_next       = win_reg;
        put_byte_en    = 1'b0;
        put_word_en    = 1'b0;
        put_byte       = 8'h00;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    word_next  = msg.msg_word;
                    cnt_next   = sat_cnt;
                    last_next  = msg.last_word;
                    bytes_next = bytes_reg + 61'(sat_cnt);
                    step_next  = 3'd0;
                    state_next = ST_ABSORB;
                end
            end

            ST_ABSORB:
            begin
                if (step_reg != cnt_reg)
                begin
                    if (fill_reg[1:0] == 2'd0 && cnt_reg == sm3_pkg::WORD_BYTES
                        && step_reg == 3'd0)
                    begin
                        put_word_en = 1'b1;
                        step_next   = sm3_pkg::WORD_BYTES;
                    end
                    else
                    begin
                        put_byte_en = 1'b1;
                        put_byte    = word_reg[2'd3 - step_reg[1:0]];
                        step_next   = step_reg + 3'd1;
                    end
                    if ((put_word_en && wrap_word) || (put_byte_en && wrap_byte))
                    begin
                        ret_next   = RET_ABSORB;
                        state_next = ST_ROUND;
                        rnd_next   = 6'd0;
                        work_next  = chain_reg;
                    end
                    else if (step_next == cnt_reg)
                    begin
                        state_next = last_reg ? ST_PAD_MARK : ST_IDLE;
                    end
                end
                else
                begin
                    state_next = last_reg ? ST_PAD_MARK : ST_IDLE;
                end
            end

            ST_PAD_MARK:
            begin
                put_byte_en = 1'b1;
                put_byte    = sm3_pkg::PAD_MARK;
                state_next  = ST_PAD_ZERO;
                if (wrap_byte)
                begin
                    ret_next   = RET_ZERO;
                    state_next = ST_ROUND;
                    rnd_next   = 6'd0;
                    work_next  = chain_reg;
                end
            end

            ST_PAD_ZERO:
            begin
                if (fill_reg == sm3_pkg::LEN_START)
                begin
                    step_next  = 3'd0;
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    put_byte_en = 1'b1;
                    if (wrap_byte)
                    begin
                        ret_next   = RET_ZERO;
                        state_next = ST_ROUND;
                        rnd_next   = 6'd0;
                        work_next  = chain_reg;
                    end
                end
            end

            ST_PAD_LEN:
            begin
                // Length bytes go out most significant first
                put_byte_en = 1'b1;
                put_byte    = len_bytes[3'd7 - step_reg];
                step_next   = step_reg + 3'd1;
                if (wrap_byte)
                begin
                    ret_next   = RET_OUT;
                    state_next = ST_ROUND;
                    rnd_next   = 6'd0;
                    work_next  = chain_reg;
                end
            end

            ST_ROUND:
            begin
                work_next[0] = tt1;
                work_next[1] = work_reg[0];
                work_next[2] = sm3_pkg::rotl32(work_reg[1], 5'd9);
                work_next[3] = work_reg[2];
                work_next[4] = sm3_pkg::perm0(tt2);
                work_next[5] = work_reg[4];
                work_next[6] = sm3_pkg::rotl32(work_reg[5], 5'd19);
                work_next[7] = work_reg[6];
                for (int i = 0; i < sm3_pkg::BlockWords - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[sm3_pkg::BlockWords - 1] = w_new;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'(sm3_pkg::Rounds - 1))
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                for (int i = 0; i < sm3_pkg::ChainWords; i++)
                begin
                    chain_next[i] = chain_reg[i] ^ work_reg[i];
                end
                unique case (ret_reg)
                    RET_ABSORB: state_next = ST_ABSORB;
                    RET_ZERO:   state_next = ST_PAD_ZERO;
                    RET_OUT:
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{digest_word: chain_reg[0] ^ work_reg[0],
                                           digest_last: 1'b0};
                        step_next      = 3'd0;
                        state_next     = ST_OUT;
                    end
                    default:    state_next = ST_IDLE;
                endcase
            end

            ST_OUT:
            begin
                if (digest_ready)
                begin
                    // Shift the digest out and the initial vector in
                    for (int i = 0; i < sm3_pkg::ChainWords - 1; i++)
                    begin
                        chain_next[i] = chain_reg[i + 1];
                    end
                    chain_next[sm3_pkg::ChainWords - 1] = sm3_pkg::IV[step_reg];
                    if (step_reg == 3'd7)
                    begin
                        out_valid_next = 1'b0;
                        bytes_next     = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        step_next     = step_reg + 3'd1;
                        out_data_next = '{digest_word: chain_reg[1],
                                          digest_last: (step_reg == 3'd6)};
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Write into the block window
        if (put_word_en)
        begin
            win_next[fill_reg[5:2]] = word_reg;
            fill_next = fill_reg + 6'd4;
        end
        else if (put_byte_en)
        begin
            win_next[fill_reg[5:2]][2'd3 - fill_reg[1:0]] = put_byte;
            fill_next = fill_reg + 6'd1;
        end
    end

    // Hold state, counters, chaining value and the digest register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_ABSORB;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            rnd_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int i = 0; i < sm3_pkg::ChainWords; i++)
            begin
                chain_reg[i] <= sm3_pkg::IV[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            rnd_reg       <= rnd_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            chain_reg     <= chain_next;
        end
    end

    // Advance the message window, working variables and input word
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
        word_reg <= word_next;
    end

    assign msg_ready    = (state_reg == ST_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest       = out_data_reg;

`ifndef SYNTH
    // Never take a message transaction while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && digest_valid))
        else $error("message accepted while digest pending");

    // Rounds run only on a complete block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (fill_reg == 6'd0))
        else $error("compression started on a partial block");

    // After the final digest word the engine is idle with a cleared counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && digest.digest_last)
        |=> (msg_ready && bytes_reg == '0 && fill_reg == 6'd0))
        else $error("engine not reinitialized after digest");

    // The last digest word flag only appears on the eighth word
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest.digest_last) |-> (step_reg == 3'd7))
        else $error("digest last flag out of place");
`endif

endmodule
